// File: design/kac_pkg.sv
package kac_pkg;

  localparam int unsigned KeyW   = 8;
  localparam int unsigned DigitW = 4;
  localparam int unsigned CountW = 2;
  localparam int unsigned DivSteps = 8;
  localparam int unsigned StepW  = $clog2(DivSteps);

  localparam logic [KeyW-1:0] KEY_ZERO = 8'h30;
  localparam logic [KeyW-1:0] KEY_NINE = 8'h39;
  localparam logic [KeyW-1:0] KEY_STAR = 8'h2A;
  localparam logic [KeyW-1:0] KEY_ADD  = 8'h41;
  localparam logic [KeyW-1:0] KEY_SUB  = 8'h42;
  localparam logic [KeyW-1:0] KEY_MUL  = 8'h43;
  localparam logic [KeyW-1:0] KEY_DIV  = 8'h44;

  // x / 10 == (x * 205) >> 11 for every x below 1029
  localparam logic [7:0] RECIP_TEN = 8'd205;
  localparam int unsigned RecipShift = 11;

  localparam logic [KeyW-1:0] HUNDRED = 8'd100;
  localparam logic [KeyW-1:0] TEN     = 8'd10;

  localparam logic ACT_ECHO   = 1'b0;
  localparam logic ACT_REDRAW = 1'b1;

  localparam logic [CountW-1:0] CNT_ONE   = 2'd1;
  localparam logic [CountW-1:0] CNT_TWO   = 2'd2;
  localparam logic [CountW-1:0] CNT_THREE = 2'd3;

  typedef enum logic [2:0] {
    KC_NONE,
    KC_DIGIT,
    KC_CLEAR,
    KC_ADD,
    KC_SUB,
    KC_MUL,
    KC_DIV
  } key_class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_CONV_LO,
    ST_CONV_HI,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_key;
    logic exec_op;
    logic div_step;
    logic conv_lo;
    logic conv_hi;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    key_class_e key_class;
    logic       div_last;
    logic       out_busy;
  } status_t;

  function automatic key_class_e classify(input logic [KeyW-1:0] key);
    key_class_e kc;
    kc = KC_NONE;
    if (key >= KEY_ZERO && key <= KEY_NINE) begin
      kc = KC_DIGIT;
    end else if (key == KEY_STAR) begin
      kc = KC_CLEAR;
    end else if (key == KEY_ADD) begin
      kc = KC_ADD;
    end else if (key == KEY_SUB) begin
      kc = KC_SUB;
    end else if (key == KEY_MUL) begin
      kc = KC_MUL;
    end else if (key == KEY_DIV) begin
      kc = KC_DIV;
    end
    return kc;
  endfunction

endpackage

// File: design/kac_ctrl.sv
module kac_ctrl
  import kac_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (status_i.key_class)
          KC_NONE: state_d = ST_IDLE;
          KC_DIV:  state_d = ST_DIV;
          default: state_d = ST_CONV_LO;
        endcase
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_CONV_LO;
      end
      ST_CONV_LO: state_d = ST_CONV_HI;
      ST_CONV_HI: state_d = ST_OUT;
      ST_OUT: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_key = in_valid_i;
      end
      ST_EXEC:    cmd_o.exec_op  = 1'b1;
      ST_DIV:     cmd_o.div_step = 1'b1;
      ST_CONV_LO: cmd_o.conv_lo  = 1'b1;
      ST_CONV_HI: cmd_o.conv_hi  = 1'b1;
      ST_OUT:     cmd_o.load_out = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

// File: design/kac_dp.sv
module kac_dp
  import kac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic [KeyW-1:0]   key_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              action_o,
  output logic [DigitW-1:0] echo_digit_o,
  output logic [KeyW-1:0]   shown_value_o,
  output logic [DigitW-1:0] hundreds_digit_o,
  output logic [DigitW-1:0] tens_digit_o,
  output logic [DigitW-1:0] ones_digit_o,
  output logic [CountW-1:0] digit_count_o
);

  logic [KeyW-1:0]   key_q;
  logic [KeyW-1:0]   acc_q, acc_d;
  logic [KeyW-1:0]   entry_q, entry_d;
  logic [KeyW-1:0]   rem_q, rem_d;
  logic [KeyW-1:0]   num_q, num_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              act_q, act_d;
  logic [DigitW-1:0] echo_q, echo_d;
  logic [4:0]        q1_q;
  logic [DigitW-1:0] ones_q, hund_q, tens_q;
  logic              out_valid_q;

  key_class_e        kc;
  logic [DigitW-1:0] digit;
  logic [KeyW-1:0]   rem_sh;
  logic              q_bit;
  logic [15:0]       prod_lo;
  logic [4:0]        q1;
  logic [12:0]       prod_hi;
  logic [1:0]        hund;

  assign kc     = classify(key_q);
  assign digit  = key_q[DigitW-1:0];

  // one restoring step, remainder kept to eight bits
  assign rem_sh = {rem_q[KeyW-2:0], num_q[KeyW-1]};
  assign q_bit  = (rem_sh >= entry_q);

  assign prod_lo = acc_q * RECIP_TEN;
  assign q1      = prod_lo[15:RecipShift];
  assign prod_hi = q1_q * RECIP_TEN;
  assign hund    = prod_hi[12:RecipShift];

  always_comb begin
    acc_d   = acc_q;
    entry_d = entry_q;
    rem_d   = rem_q;
    num_d   = num_q;
    step_d  = step_q;
    act_d   = act_q;
    echo_d  = echo_q;
    if (cmd_i.exec_op) begin
      act_d  = ACT_REDRAW;
      echo_d = '0;
      case (kc)
        KC_DIGIT: begin
          entry_d = {entry_q[4:0], 3'b000} + {entry_q[6:0], 1'b0} + {4'd0, digit};
          act_d   = ACT_ECHO;
          echo_d  = digit;
        end
        KC_CLEAR: begin
          acc_d   = '0;
          entry_d = '0;
        end
        KC_ADD: begin
          acc_d   = acc_q + entry_q;
          entry_d = '0;
        end
        KC_SUB: begin
          acc_d   = acc_q - entry_q;
          entry_d = '0;
        end
        KC_MUL: begin
          acc_d   = 8'(acc_q * entry_q);
          entry_d = '0;
        end
        KC_DIV: begin
          rem_d  = '0;
          num_d  = acc_q;
          step_d = '0;
        end
        default: ;
      endcase
    end
    if (cmd_i.div_step) begin
      rem_d  = q_bit ? (rem_sh - entry_q) : rem_sh;
      num_d  = {num_q[KeyW-2:0], q_bit};
      step_d = step_q + 1'b1;
      if (status_o.div_last) begin
        acc_d   = {num_q[KeyW-2:0], q_bit};
        entry_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      entry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      entry_q <= entry_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) key_q <= key_i;
    rem_q  <= rem_d;
    num_q  <= num_d;
    step_q <= step_d;
    act_q  <= act_d;
    echo_q <= echo_d;
    if (cmd_i.conv_lo) begin
      q1_q   <= q1;
      ones_q <= 4'(acc_q - ({q1, 3'b000} + {2'b00, q1, 1'b0}));
    end
    if (cmd_i.conv_hi) begin
      hund_q <= {2'b00, hund};
      tens_q <= 4'(q1_q - ({hund, 3'b000} + {2'b00, hund, 1'b0}));
    end
    if (cmd_i.load_out) begin
      action_o         <= act_q;
      echo_digit_o     <= echo_q;
      shown_value_o    <= acc_q;
      hundreds_digit_o <= hund_q;
      tens_digit_o     <= tens_q;
      ones_digit_o     <= ones_q;
      digit_count_o    <= (acc_q >= HUNDRED) ? CNT_THREE :
                          (acc_q >= TEN)     ? CNT_TWO : CNT_ONE;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.key_class = kc;
  assign status_o.div_last  = (step_q == StepW'(DivSteps - 1));
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

// File: design/keypad_accumulator_calculator.sv
// Keypad accumulator calculator. One ASCII key code arrives per input
// transaction. Digit keys grow an 8-bit entry (entry*10+digit, wrapping) and
// echo the digit; '*' clears accumulator and entry; 'A'..'D' apply +, -, *, /
// of accumulator by entry (all mod 256, divide by zero gives 255), clear the
// entry and ask for a redraw with the accumulator split into decimal digits
// and a count of significant digits. Any other key is dropped silently.
// Flow: a key that yields a result passes EXEC, CONV_LO, CONV_HI and OUT
// from its acceptance until ready again; 'D' also runs its eight-step
// restoring divide in DIV, one quotient bit per cycle; an ignored key goes
// from EXEC back to IDLE. The decimal split uses a reciprocal multiply. A
// finished result sits in the output register while the next key is taken;
// the block stalls only if a new result is ready before the old one is taken.
module keypad_accumulator_calculator
  import kac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // key input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [3:0] echo_digit, [11:4] shown_value,
                                      // [15:12] hundreds_digit, [19:16] tens_digit,
                                      // [23:20] ones_digit, [25:24] digit_count
  output logic        m_axis_tuser    // [0] action: 0 echo, 1 redraw
);

  cmd_t              cmd;
  status_t           status;
  logic [DigitW-1:0] echo_digit;
  logic [KeyW-1:0]   shown_value;
  logic [DigitW-1:0] hundreds_digit;
  logic [DigitW-1:0] tens_digit;
  logic [DigitW-1:0] ones_digit;
  logic [CountW-1:0] digit_count;

  kac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kac_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .key_i            (s_axis_tdata),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .action_o         (m_axis_tuser),
    .echo_digit_o     (echo_digit),
    .shown_value_o    (shown_value),
    .hundreds_digit_o (hundreds_digit),
    .tens_digit_o     (tens_digit),
    .ones_digit_o     (ones_digit),
    .digit_count_o    (digit_count)
  );

  assign m_axis_tdata = {6'd0, digit_count, ones_digit, tens_digit, hundreds_digit,
                         shown_value, echo_digit};

  // a key is worked on alone: no second key straight after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  else $error("key accepted while previous key in progress");

  // decimal split must rebuild the shown value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (12'(hundreds_digit) * 12'd100 + 12'(tens_digit) * 12'd10
                       + 12'(ones_digit)) == 12'(shown_value))
  else $error("decimal digits do not match shown value");

  // digit count agrees with leading zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && digit_count == CNT_ONE |-> hundreds_digit == '0 && tens_digit == '0)
  else $error("digit count inconsistent with digits");

  // a redraw carries no echo digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> echo_digit == '0)
  else $error("echo digit set on redraw");

endmodule

// File: tb/sv/tb_keypad_accumulator_calculator.sv
`timescale 1ns / 1ps

// Self-checking bench for the keypad accumulator calculator. Key codes go in
// on the slave stream. Every accepted transaction also runs through a local
// model of the accumulator and entry registers. Each output transaction is
// checked field by field against the oldest predicted display update.
module tb_keypad_accumulator_calculator;
  import kac_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;  // cycles with no transaction at all
  localparam int unsigned HoldCycles    = 300;   // long receiver hold-off
  localparam int unsigned RandResults   = 1450;  // random keys that give a result
  localparam int unsigned SettleCycles  = 20;    // well above the length of a divide

  // one expected display update
  typedef struct {
    logic              action;
    logic [DigitW-1:0] echo;
    logic [KeyW-1:0]   shown;
    logic [DigitW-1:0] hundreds;
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] ones;
    logic [CountW-1:0] count;
  } disp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  // model state, mirrors the accumulator and the entry register
  logic [KeyW-1:0] calc_acc;
  logic [KeyW-1:0] calc_entry;

  disp_t       disp_q[$];       // display updates still owed by the block
  int unsigned errors;
  int unsigned results_predicted;

  // sender shaping: bursts of random length, gaps of 1..tx_gap_max (0 = none)
  int unsigned burst_left;
  int unsigned tx_gap_max;
  // receiver shaping
  bit          rx_stall_en;
  bit          rx_hold_req;

  int unsigned idle_cycles;

  keypad_accumulator_calculator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // [7:0] key
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),    // [3:0] echo, [11:4] shown, [15:12] hundreds,
                                      // [19:16] tens, [23:20] ones, [25:24] count
    .m_axis_tuser  (m_axis_tuser)     // [0] action
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Fills the display fields from the current accumulator.
  function automatic disp_t show_acc(input logic action, input logic [DigitW-1:0] echo);
    disp_t d;
    d.action   = action;
    d.echo     = echo;
    d.shown    = calc_acc;
    d.hundreds = DigitW'(calc_acc / 100);
    d.tens     = DigitW'((calc_acc / 10) % 10);
    d.ones     = DigitW'(calc_acc % 10);
    if (calc_acc >= 100) begin
      d.count = CNT_THREE;
    end else if (calc_acc >= 10) begin
      d.count = CNT_TWO;
    end else begin
      d.count = CNT_ONE;
    end
    return d;
  endfunction

  // Applies one key to the model. Returns 1 when the key produces a display
  // update, handed back in d.
  function automatic bit calc_key(input logic [KeyW-1:0] k, output disp_t d);
    logic [DigitW-1:0] digit;
    digit = '0;
    d     = show_acc(ACT_ECHO, '0);
    if (k >= KEY_ZERO && k <= KEY_NINE) begin
      digit      = DigitW'(k - KEY_ZERO);
      calc_entry = KeyW'(calc_entry * 10 + digit);  // wraps mod 256
      d          = show_acc(ACT_ECHO, digit);
      return 1'b1;
    end
    if (k == KEY_STAR) begin
      calc_acc   = '0;
      calc_entry = '0;
      d          = show_acc(ACT_REDRAW, '0);
      return 1'b1;
    end
    if (k >= KEY_ADD && k <= KEY_DIV) begin
      case (k)
        KEY_ADD: calc_acc = calc_acc + calc_entry;
        KEY_SUB: calc_acc = calc_acc - calc_entry;
        KEY_MUL: calc_acc = KeyW'(calc_acc * calc_entry);
        default: begin
          // restoring divide sets every quotient bit for a zero divisor
          calc_acc = (calc_entry == '0) ? '1 : calc_acc / calc_entry;
        end
      endcase
      calc_entry = '0;
      d          = show_acc(ACT_REDRAW, '0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Mostly well-formed keypad use, with a slice of arbitrary codes as noise.
  function automatic logic [KeyW-1:0] rand_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return KEY_ZERO + KeyW'($urandom_range(0, 9));
    end else if (r < 85) begin
      return KEY_ADD + KeyW'($urandom_range(0, 3));
    end else if (r < 90) begin
      return KEY_STAR;
    end
    return KeyW'($urandom_range(0, 255));
  endfunction

  // Offers one key and waits for its transaction. Called at a rising edge.
  task automatic send_key(input logic [KeyW-1:0] k);
    disp_t d;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (tx_gap_max != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, tx_gap_max)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    if (calc_key(k, d)) begin
      disp_q.push_back(d);
      results_predicted++;
    end
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (disp_q.size() != 0) @(posedge clk_i);
  endtask

  // Extremes: entry overflow, all four operations, wrap on subtract and
  // multiply, division by zero, a zero quotient, then codes next to the
  // valid ranges, and 00 and FF, that must be dropped.
  task automatic test_directed();
    logic [KeyW-1:0] keys[$];
    keys = '{KEY_STAR, "9", "9", "9", KEY_ADD, "5", KEY_SUB, "0", KEY_DIV,
             "2", "5", "5", KEY_MUL, "1", KEY_SUB, "1", KEY_SUB, "3", KEY_DIV,
             "2", "0", "0", KEY_DIV,
             8'h00, 8'hFF, 8'h2F, 8'h3A, 8'h40, 8'h45};
    foreach (keys[i]) send_key(keys[i]);
    stop_input();
    wait_drained();
  endtask

  // Receiver holds off while keys keep coming back to back: the output
  // register fills and the block has to stall its input.
  task automatic test_hold_off();
    tx_gap_max  = 0;
    rx_hold_req = 1'b1;
    repeat (30) send_key(rand_key());
    stop_input();
    wait_drained();
  endtask

  // Short runs, each followed by a pause until every update has come out.
  task automatic test_drain_pause();
    tx_gap_max = 4;
    repeat (8) begin
      repeat ($urandom_range(3, 10)) send_key(rand_key());
      stop_input();
      wait_drained();
    end
  endtask

  // Long random run; idling on both sides is reshuffled every few hundred
  // transactions so there are stretches with no idling at all.
  task automatic test_random();
    int unsigned start;
    int unsigned next_shuffle;
    start        = results_predicted;
    next_shuffle = start;
    while (results_predicted - start < RandResults) begin
      if (results_predicted >= next_shuffle) begin
        next_shuffle = results_predicted + 200;
        rx_stall_en  = $urandom_range(0, 3) != 0;
        tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
      send_key(rand_key());
    end
    stop_input();
    wait_drained();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    calc_acc          = '0;
    calc_entry        = '0;
    errors            = 0;
    results_predicted = 0;
    burst_left        = 0;
    tx_gap_max        = 6;
    rx_stall_en       = 1'b1;
    rx_hold_req       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_hold_off();
    test_drain_pause();
    test_random();

    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0 && disp_q.size() == 0) begin
      $display("tb_keypad_accumulator_calculator OK");
    end else begin
      $display("tb_keypad_accumulator_calculator NOT OK");
    end
    $finish;
  end

  // Receiver: ready and stall runs of random length; a hold-off request
  // turns into a long stall counted here.
  initial begin
    int unsigned hold_cnt;
    int unsigned run_left;
    bit          ready_phase;
    hold_cnt    = 0;
    run_left    = 0;
    ready_phase = 1'b1;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt != 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_cnt    = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else if (!rx_stall_en) begin
        m_axis_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          ready_phase = !ready_phase;
          run_left    = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        run_left--;
        m_axis_tready <= ready_phase;
      end
    end
  end

  // Checker: compares each output transaction with the oldest expectation.
  always @(posedge clk_i) begin
    disp_t exp_d;
    disp_t act_d;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_d.action   = m_axis_tuser;
      act_d.echo     = m_axis_tdata[3:0];
      act_d.shown    = m_axis_tdata[11:4];
      act_d.hundreds = m_axis_tdata[15:12];
      act_d.tens     = m_axis_tdata[19:16];
      act_d.ones     = m_axis_tdata[23:20];
      act_d.count    = m_axis_tdata[25:24];
      if (disp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result tuser %b tdata %h", $time, m_axis_tuser,
                 m_axis_tdata);
      end else begin
        exp_d = disp_q.pop_front();
        if (act_d.action !== exp_d.action) begin
          errors++;
          $display("%0t: action exp %b got %b", $time, exp_d.action, act_d.action);
        end
        if (act_d.echo !== exp_d.echo) begin
          errors++;
          $display("%0t: echo_digit exp %0d got %0d", $time, exp_d.echo, act_d.echo);
        end
        if (act_d.shown !== exp_d.shown) begin
          errors++;
          $display("%0t: shown_value exp %0d got %0d", $time, exp_d.shown, act_d.shown);
        end
        if (act_d.hundreds !== exp_d.hundreds) begin
          errors++;
          $display("%0t: hundreds_digit exp %0d got %0d", $time, exp_d.hundreds,
                   act_d.hundreds);
        end
        if (act_d.tens !== exp_d.tens) begin
          errors++;
          $display("%0t: tens_digit exp %0d got %0d", $time, exp_d.tens, act_d.tens);
        end
        if (act_d.ones !== exp_d.ones) begin
          errors++;
          $display("%0t: ones_digit exp %0d got %0d", $time, exp_d.ones, act_d.ones);
        end
        if (act_d.count !== exp_d.count) begin
          errors++;
          $display("%0t: digit_count exp %0d got %0d", $time, exp_d.count, act_d.count);
        end
        if (m_axis_tdata[31:26] !== '0) begin
          errors++;
          $display("%0t: tdata padding exp 0 got %h", $time, m_axis_tdata[31:26]);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("tb_keypad_accumulator_calculator NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule

// File: files.f
design/kac_pkg.sv
design/kac_ctrl.sv
design/kac_dp.sv
design/keypad_accumulator_calculator.sv
tb/sv/tb_keypad_accumulator_calculator.sv
